// ===== rtl/core/trsd_pkg.sv =====
// Shared types and constants for the TGA true-color stream decoder.
// Used by trsd_parser and tga_rgb_stream_decoder_top; depends on nothing else.
package trsd_pkg;

   // Parser phase, one value per stretch of the file.
   typedef enum logic [2:0] {
      PH_HEADER,
      PH_HEADER_BADBPP,
      PH_ID,
      PH_PIXELS,
      PH_DONE
   } phase_type;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_SHORT_HEADER = 3'd1;
   localparam logic [2:0] ERR_COLOR_MAPPED = 3'd2;
   localparam logic [2:0] ERR_NOT_RGB      = 3'd3;
   localparam logic [2:0] ERR_BAD_DEPTH    = 3'd4;
   localparam logic [2:0] ERR_SHORT_DATA   = 3'd5;

   // Byte offsets within the 18-byte header.
   localparam logic [4:0] HDR_ID_LENGTH = 5'd0;
   localparam logic [4:0] HDR_MAP_TYPE  = 5'd1;
   localparam logic [4:0] HDR_DATA_TYPE = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_DEPTH     = 5'd16;
   localparam logic [4:0] HDR_LAST      = 5'd17;

   localparam logic [7:0] MAP_TRUE_COLOR    = 8'd0;
   localparam logic [7:0] TYPE_UNCOMP_RGB   = 8'd2;
   localparam logic [7:0] DEPTH_24          = 8'd24;
   localparam logic [7:0] DEPTH_32          = 8'd32;
   localparam logic [7:0] OPAQUE_ALPHA      = 8'hFF;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [2:0]  error_code;
      logic        has_alpha;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [31:0] pixel_value;
      logic [31:0] dest_index;
      logic        last_item;
   } result_type;

endpackage

// ===== rtl/core/tga_rgb_stream_decoder_top.sv =====
// Top level of the TGA true-color stream decoder: input register, parser, result register.
// Depends on trsd_pkg and trsd_parser.

// The decoder takes one file byte per item and accepts an item in every cycle while the
// result side keeps up. Each accepted byte is held in the input register, and the result it
// yields, if any, goes into the result register when the byte leaves the input register
// and is presented from there until taken. The header check, the (height-1)*width
// row-base multiply and the per-pixel index add all sit between those two registers. A
// result waiting behind a stall holds the byte in the input register and, only then,
// stalls the input side.
module tga_rgb_stream_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_file,
   input  logic        req_end_of_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_has_alpha,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [31:0] rsp_pixel_value,
   output logic [31:0] rsp_dest_index,
   output logic        rsp_last_item
);
   import trsd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_sof_ff;
   logic       in_eod_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       out_free;
   logic       advance;
   logic       accept;
   logic       res_valid;
   result_type res;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   assign out_valid_in = out_free ? (advance && res_valid) : out_valid_ff;

   trsd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .data_byte     (in_byte_ff),
      .start_of_file (in_sof_ff),
      .end_of_data   (in_eod_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_sof_ff  <= req_start_of_file;
         in_eod_ff  <= req_end_of_data;
      end
      if (advance && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_ff.result_kind;
   assign rsp_error_code   = out_ff.error_code;
   assign rsp_has_alpha    = out_ff.has_alpha;
   assign rsp_image_width  = out_ff.image_width;
   assign rsp_image_height = out_ff.image_height;
   assign rsp_pixel_value  = out_ff.pixel_value;
   assign rsp_dest_index   = out_ff.dest_index;
   assign rsp_last_item    = out_ff.last_item;

   // The input side is held back only by a result that is waiting to be taken.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

   // Every error ends the file and carries a nonzero code.
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KIND_ERROR))
         |-> (rsp_last_item && (rsp_error_code != ERR_NONE)))
      else $error("error result without code or last flag");

   // Pixels only come from a nonempty image and carry no error code.
   a_pixel_sane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KIND_PIXEL))
         |-> ((rsp_error_code == ERR_NONE) && (rsp_image_width != 16'd0)
              && (rsp_image_height != 16'd0)))
      else $error("pixel result from an empty or failed header");

   // A header that does not close the file announces a nonempty image.
   a_header_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KIND_HEADER) && !rsp_last_item)
         |-> ((rsp_image_width != 16'd0) && (rsp_image_height != 16'd0)))
      else $error("open header result for an empty image");

endmodule

// ===== rtl/core/trsd_parser.sv =====
// Header parser, pixel assembler and flipped-index counters of the TGA decoder.
// Depends on trsd_pkg; instantiated by tga_rgb_stream_decoder_top.
module trsd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                start_of_file,
   input  logic                end_of_data,
   output logic                res_valid,
   output trsd_pkg::result_type res
);
   import trsd_pkg::*;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [4:0]  hcount_ff, hcount_in, cur_hcount;
   logic [7:0]  id_length_ff, id_length_in, cur_id_length;
   logic [7:0]  id_remaining_ff, id_remaining_in, cur_id_remaining;
   logic [1:0]  map_ok_ff, map_ok_in, cur_map_ok;
   logic [15:0] width_ff, width_in, cur_width;
   logic [15:0] height_ff, height_in, cur_height;
   logic        alpha_ff, alpha_in, cur_alpha;
   logic [23:0] pix_bytes_ff, pix_bytes_in, cur_pix_bytes;
   logic [1:0]  bip_ff, bip_in, cur_bip;
   logic [15:0] col_ff, col_in, cur_col;
   logic [31:0] row_base_ff, row_base_in, cur_row_base;
   logic [15:0] rows_left_ff, rows_left_in, cur_rows_left;

   logic        restart;
   logic [2:0]  hdr_err;
   logic        empty_image;
   logic [15:0] height_m1;
   logic [31:0] row_base_init;
   logic [2:0]  need;
   logic        pix_complete;
   logic [16:0] col_next;
   logic        row_end;
   logic [15:0] rows_left_dec;
   logic [7:0]  id_remaining_dec;
   logic [31:0] pixel_word;
   logic [31:0] dest_word;
   logic [23:0] pix_merged;

   // A start flag clears the parser before its own byte is handled.
   assign restart          = step && start_of_file;
   assign cur_phase        = restart ? PH_HEADER : phase_ff;
   assign cur_hcount       = restart ? 5'd0  : hcount_ff;
   assign cur_id_length    = restart ? 8'd0  : id_length_ff;
   assign cur_id_remaining = restart ? 8'd0  : id_remaining_ff;
   assign cur_map_ok       = restart ? 2'd0  : map_ok_ff;
   assign cur_width        = restart ? 16'd0 : width_ff;
   assign cur_height       = restart ? 16'd0 : height_ff;
   assign cur_alpha        = restart ? 1'b0  : alpha_ff;
   assign cur_pix_bytes    = restart ? 24'd0 : pix_bytes_ff;
   assign cur_bip          = restart ? 2'd0  : bip_ff;
   assign cur_col          = restart ? 16'd0 : col_ff;
   assign cur_row_base     = restart ? 32'd0 : row_base_ff;
   assign cur_rows_left    = restart ? 16'd0 : rows_left_ff;

   // Header checks, applied when the last header byte arrives.
   always_comb begin
      if (!cur_map_ok[0]) begin
         hdr_err = ERR_COLOR_MAPPED;
      end else if (!cur_map_ok[1]) begin
         hdr_err = ERR_NOT_RGB;
      end else if (cur_phase == PH_HEADER_BADBPP) begin
         hdr_err = ERR_BAD_DEPTH;
      end else begin
         hdr_err = ERR_NONE;
      end
   end

   assign empty_image   = (cur_width == 16'd0) || (cur_height == 16'd0);
   assign height_m1     = cur_height - 16'd1;
   assign row_base_init = {16'd0, height_m1} * {16'd0, cur_width};

   assign need             = cur_alpha ? 3'd4 : 3'd3;
   assign pix_complete     = ({1'b0, cur_bip} + 3'd1) >= need;
   assign col_next         = {1'b0, cur_col} + 17'd1;
   assign row_end          = col_next >= {1'b0, cur_width};
   assign rows_left_dec    = cur_rows_left - 16'd1;
   assign id_remaining_dec = cur_id_remaining - 8'd1;
   assign dest_word        = cur_row_base + {16'd0, cur_col};

   always_comb begin
      if (cur_alpha) begin
         pixel_word = {data_byte, cur_pix_bytes};
      end else begin
         pixel_word = {OPAQUE_ALPHA, data_byte, cur_pix_bytes[15:0]};
      end
   end

   always_comb begin
      pix_merged = cur_pix_bytes;
      case (cur_bip)
         2'd0: begin
            pix_merged[7:0] = data_byte;
         end
         2'd1: begin
            pix_merged[15:8] = data_byte;
         end
         2'd2: begin
            pix_merged[23:16] = data_byte;
         end
         default: begin
            pix_merged = cur_pix_bytes;
         end
      endcase
   end

   // Next-state logic.
   always_comb begin
      phase_in        = cur_phase;
      hcount_in       = cur_hcount;
      id_length_in    = cur_id_length;
      id_remaining_in = cur_id_remaining;
      map_ok_in       = cur_map_ok;
      width_in        = cur_width;
      height_in       = cur_height;
      alpha_in        = cur_alpha;
      pix_bytes_in    = cur_pix_bytes;
      bip_in          = cur_bip;
      col_in          = cur_col;
      row_base_in     = cur_row_base;
      rows_left_in    = cur_rows_left;
      if (step && (cur_phase != PH_DONE)) begin
         if (end_of_data) begin
            phase_in = PH_DONE;
         end else begin
            case (cur_phase)
               PH_HEADER, PH_HEADER_BADBPP: begin
                  hcount_in = cur_hcount + 5'd1;
                  case (cur_hcount)
                     HDR_ID_LENGTH: id_length_in = data_byte;
                     HDR_MAP_TYPE: begin
                        if (data_byte == MAP_TRUE_COLOR) map_ok_in[0] = 1'b1;
                     end
                     HDR_DATA_TYPE: begin
                        if (data_byte == TYPE_UNCOMP_RGB) map_ok_in[1] = 1'b1;
                     end
                     HDR_WIDTH_LO:  width_in[7:0]   = data_byte;
                     HDR_WIDTH_HI:  width_in[15:8]  = data_byte;
                     HDR_HEIGHT_LO: height_in[7:0]  = data_byte;
                     HDR_HEIGHT_HI: height_in[15:8] = data_byte;
                     HDR_DEPTH: begin
                        alpha_in = (data_byte == DEPTH_32);
                        if ((data_byte != DEPTH_24) && (data_byte != DEPTH_32)) begin
                           phase_in = PH_HEADER_BADBPP;
                        end
                     end
                     HDR_LAST: begin
                        if ((hdr_err != ERR_NONE) || empty_image) begin
                           phase_in = PH_DONE;
                        end else begin
                           rows_left_in    = cur_height;
                           row_base_in     = row_base_init;
                           col_in          = 16'd0;
                           bip_in          = 2'd0;
                           pix_bytes_in    = 24'd0;
                           id_remaining_in = cur_id_length;
                           phase_in = (cur_id_length != 8'd0) ? PH_ID : PH_PIXELS;
                        end
                     end
                     default: begin
                        hcount_in = cur_hcount + 5'd1;
                     end
                  endcase
               end
               PH_ID: begin
                  id_remaining_in = id_remaining_dec;
                  if (id_remaining_dec == 8'd0) phase_in = PH_PIXELS;
               end
               PH_PIXELS: begin
                  if (!pix_complete) begin
                     pix_bytes_in = pix_merged;
                     bip_in       = cur_bip + 2'd1;
                  end else begin
                     pix_bytes_in = 24'd0;
                     bip_in       = 2'd0;
                     if (row_end) begin
                        col_in       = 16'd0;
                        rows_left_in = rows_left_dec;
                        row_base_in  = cur_row_base - {16'd0, cur_width};
                        if (rows_left_dec == 16'd0) phase_in = PH_DONE;
                     end else begin
                        col_in = col_next[15:0];
                     end
                  end
               end
               default: begin
                  phase_in = cur_phase;
               end
            endcase
         end
      end
   end

   // Result logic.
   always_comb begin
      res_valid = 1'b0;
      res       = '0;
      if (step && (cur_phase != PH_DONE)) begin
         if (end_of_data) begin
            res_valid       = 1'b1;
            res.result_kind = KIND_ERROR;
            res.error_code  = ((cur_phase == PH_HEADER) || (cur_phase == PH_HEADER_BADBPP))
                              ? ERR_SHORT_HEADER : ERR_SHORT_DATA;
            res.last_item   = 1'b1;
         end else if (((cur_phase == PH_HEADER) || (cur_phase == PH_HEADER_BADBPP))
                      && (cur_hcount == HDR_LAST)) begin
            res_valid = 1'b1;
            if (hdr_err != ERR_NONE) begin
               res.result_kind = KIND_ERROR;
               res.error_code  = hdr_err;
               res.last_item   = 1'b1;
            end else begin
               res.result_kind  = KIND_HEADER;
               res.has_alpha    = cur_alpha;
               res.image_width  = cur_width;
               res.image_height = cur_height;
               res.last_item    = empty_image;
            end
         end else if ((cur_phase == PH_PIXELS) && pix_complete) begin
            res_valid        = 1'b1;
            res.result_kind  = KIND_PIXEL;
            res.has_alpha    = cur_alpha;
            res.image_width  = cur_width;
            res.image_height = cur_height;
            res.pixel_value  = pixel_word;
            res.dest_index   = dest_word;
            res.last_item    = row_end && (rows_left_dec == 16'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         hcount_ff       <= 5'd0;
         id_length_ff    <= 8'd0;
         id_remaining_ff <= 8'd0;
         map_ok_ff       <= 2'd0;
         width_ff        <= 16'd0;
         height_ff       <= 16'd0;
         alpha_ff        <= 1'b0;
         pix_bytes_ff    <= 24'd0;
         bip_ff          <= 2'd0;
         col_ff          <= 16'd0;
         row_base_ff     <= 32'd0;
         rows_left_ff    <= 16'd0;
      end else begin
         phase_ff        <= phase_in;
         hcount_ff       <= hcount_in;
         id_length_ff    <= id_length_in;
         id_remaining_ff <= id_remaining_in;
         map_ok_ff       <= map_ok_in;
         width_ff        <= width_in;
         height_ff       <= height_in;
         alpha_ff        <= alpha_in;
         pix_bytes_ff    <= pix_bytes_in;
         bip_ff          <= bip_in;
         col_ff          <= col_in;
         row_base_ff     <= row_base_in;
         rows_left_ff    <= rows_left_in;
      end
   end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for tga_rgb_stream_decoder_top: drives TGA file bytes over the
// valid/stall request channel and checks each result against a behavioral decoder or a hand-written expectation.
// Depends on trsd_pkg and the decoder RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import trsd_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int TAIL_CYCLES     = 16;
   localparam int HOLD_CYCLES     = 80;
   localparam int ITEMS_PER_PHASE = 320;
   localparam int MAX_REPORTS     = 10;

   // One request item, with an optional hand-written expectation.
   typedef struct packed {
      logic [7:0] data;
      logic       sof;
      logic       eod;
      logic       fixed;
      result_type want;
   } stim_row_type;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic [7:0]  req_data_byte     = 8'd0;
   logic        req_start_of_file = 1'b0;
   logic        req_end_of_data   = 1'b0;
   logic        rsp_stall         = 1'b0;
   logic        row_fixed         = 1'b0;
   result_type  row_want          = '0;
   logic        req_stall;
   logic        rsp_valid;
   logic [1:0]  rsp_result_kind;
   logic [2:0]  rsp_error_code;
   logic        rsp_has_alpha;
   logic [15:0] rsp_image_width;
   logic [15:0] rsp_image_height;
   logic [31:0] rsp_pixel_value;
   logic [31:0] rsp_dest_index;
   logic        rsp_last_item;

   stim_row_type stim_q[$];
   result_type  decoded_queue[$];
   int          send_idle_pct  = 0;
   int          rsp_stall_pct  = 0;
   int          hold_left      = 0;
   bit          hold_request   = 1'b0;
   int          mismatch_count = 0;
   int          parsed_bytes   = 0;
   int          quiet_cycles   = 0;

   // Decoder state kept in step with the accepted items.
   phase_type   ps_phase;
   logic [4:0]  hdr_count;
   logic [7:0]  id_len;
   logic [7:0]  id_left;
   logic [1:0]  map_type_ok;
   logic [15:0] width_reg;
   logic [15:0] height_reg;
   logic        alpha_mode;
   logic [23:0] pixel_bytes;
   logic [1:0]  byte_in_pixel;
   logic [15:0] col_count;
   logic [31:0] row_base;
   logic [15:0] rows_left;

   tga_rgb_stream_decoder_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_start_of_file (req_start_of_file),
      .req_end_of_data   (req_end_of_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_error_code    (rsp_error_code),
      .rsp_has_alpha     (rsp_has_alpha),
      .rsp_image_width   (rsp_image_width),
      .rsp_image_height  (rsp_image_height),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_dest_index    (rsp_dest_index),
      .rsp_last_item     (rsp_last_item)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic clear_parser();
      ps_phase      = PH_HEADER;
      hdr_count     = '0;
      id_len        = '0;
      id_left       = '0;
      map_type_ok   = '0;
      width_reg     = '0;
      height_reg    = '0;
      alpha_mode    = 1'b0;
      pixel_bytes   = '0;
      byte_in_pixel = '0;
      col_count     = '0;
      row_base      = '0;
      rows_left     = '0;
   endtask

   // Advances the decoder by one item; live is low when the item is simply ignored.
   task automatic decode_byte(input logic [7:0] b, input logic sof, input logic eod,
                              output logic live, output logic got, output result_type r);
      logic [2:0] err;
      logic [2:0] need;
      r   = '0;
      got = 1'b0;
      if (sof) clear_parser();
      live = (ps_phase != PH_DONE);
      if (!live) return;
      if (eod) begin
         r.result_kind = KIND_ERROR;
         r.error_code  = (ps_phase == PH_ID || ps_phase == PH_PIXELS) ? ERR_SHORT_DATA
                                                                     : ERR_SHORT_HEADER;
         r.last_item   = 1'b1;
         ps_phase      = PH_DONE;
         got           = 1'b1;
         return;
      end
      case (ps_phase)
         PH_HEADER, PH_HEADER_BADBPP: begin
            case (hdr_count)
               HDR_ID_LENGTH: id_len = b;
               HDR_MAP_TYPE:  if (b == MAP_TRUE_COLOR) map_type_ok[0] = 1'b1;
               HDR_DATA_TYPE: if (b == TYPE_UNCOMP_RGB) map_type_ok[1] = 1'b1;
               HDR_WIDTH_LO:  width_reg[7:0] = b;
               HDR_WIDTH_HI:  width_reg[15:8] = b;
               HDR_HEIGHT_LO: height_reg[7:0] = b;
               HDR_HEIGHT_HI: height_reg[15:8] = b;
               HDR_DEPTH: begin
                  alpha_mode = (b == DEPTH_32);
                  if (b != DEPTH_24 && b != DEPTH_32) ps_phase = PH_HEADER_BADBPP;
               end
               default: ;
            endcase
            if (hdr_count == HDR_LAST) begin
               got = 1'b1;
               if (!map_type_ok[0]) err = ERR_COLOR_MAPPED;
               else if (!map_type_ok[1]) err = ERR_NOT_RGB;
               else if (ps_phase == PH_HEADER_BADBPP) err = ERR_BAD_DEPTH;
               else err = ERR_NONE;
               if (err != ERR_NONE) begin
                  r.result_kind = KIND_ERROR;
                  r.error_code  = err;
                  r.last_item   = 1'b1;
                  ps_phase      = PH_DONE;
               end else begin
                  r.result_kind  = KIND_HEADER;
                  r.has_alpha    = alpha_mode;
                  r.image_width  = width_reg;
                  r.image_height = height_reg;
                  if (width_reg == 0 || height_reg == 0) begin
                     r.last_item = 1'b1;
                     ps_phase    = PH_DONE;
                  end else begin
                     rows_left     = height_reg;
                     row_base      = {16'd0, height_reg - 16'd1} * {16'd0, width_reg};
                     col_count     = '0;
                     byte_in_pixel = '0;
                     pixel_bytes   = '0;
                     id_left       = id_len;
                     ps_phase      = (id_len != 0) ? PH_ID : PH_PIXELS;
                  end
               end
            end
            hdr_count = hdr_count + 5'd1;
         end
         PH_ID: begin
            id_left = id_left - 8'd1;
            if (id_left == 0) ps_phase = PH_PIXELS;
         end
         PH_PIXELS: begin
            need = alpha_mode ? 3'd4 : 3'd3;
            if ({1'b0, byte_in_pixel} + 3'd1 < need) begin
               pixel_bytes   = pixel_bytes | ({16'd0, b} << (8 * byte_in_pixel));
               byte_in_pixel = byte_in_pixel + 2'd1;
            end else begin
               got            = 1'b1;
               r.result_kind  = KIND_PIXEL;
               r.has_alpha    = alpha_mode;
               r.image_width  = width_reg;
               r.image_height = height_reg;
               r.pixel_value  = alpha_mode ? {b, pixel_bytes}
                                           : {OPAQUE_ALPHA, b, pixel_bytes[15:0]};
               r.dest_index   = row_base + {16'd0, col_count};
               pixel_bytes    = '0;
               byte_in_pixel  = '0;
               col_count      = col_count + 16'd1;
               if (col_count >= width_reg) begin
                  col_count = '0;
                  rows_left = rows_left - 16'd1;
                  row_base  = row_base - {16'd0, width_reg};
                  if (rows_left == 0) begin
                     r.last_item = 1'b1;
                     ps_phase    = PH_DONE;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic add_item(input logic [7:0] data, input logic sof, input logic eod,
                           input logic fixed, input result_type want);
      stim_row_type s;
      s.data  = data;
      s.sof   = sof;
      s.eod   = eod;
      s.fixed = fixed;
      s.want  = want;
      stim_q.push_back(s);
   endtask

   // Queues one random file: mostly well-formed, some with broken headers or cut short.
   task automatic build_file();
      logic [7:0]  hdr [18];
      logic [15:0] w;
      logic [15:0] h;
      logic        first_sof;
      logic        good;
      logic        cut_short;
      int          pick;
      int          cut_at;
      int          n_bytes;
      int          need;
      int          i;
      first_sof = ($urandom_range(99) < 95);
      for (i = 0; i < 18; i++) hdr[i] = 8'($urandom_range(255));
      pick = $urandom_range(99);
      hdr[HDR_ID_LENGTH] = (pick < 60) ? 8'd0 : (pick < 95) ? 8'($urandom_range(1, 3))
                                                           : 8'($urandom_range(255));
      if ($urandom_range(99) < 92) hdr[HDR_MAP_TYPE] = MAP_TRUE_COLOR;
      if ($urandom_range(99) < 92) hdr[HDR_DATA_TYPE] = TYPE_UNCOMP_RGB;
      pick = $urandom_range(99);
      if (pick < 45) hdr[HDR_DEPTH] = DEPTH_24;
      else if (pick < 90) hdr[HDR_DEPTH] = DEPTH_32;
      pick = $urandom_range(99);
      w = (pick < 6) ? 16'd0 : (pick < 12) ? 16'($urandom_range(65535))
                                           : 16'($urandom_range(1, 5));
      pick = $urandom_range(99);
      h = (pick < 6) ? 16'd0 : (pick < 12) ? 16'($urandom_range(65535))
                                           : 16'($urandom_range(1, 5));
      {hdr[HDR_WIDTH_HI], hdr[HDR_WIDTH_LO]}   = w;
      {hdr[HDR_HEIGHT_HI], hdr[HDR_HEIGHT_LO]} = h;
      good = hdr[HDR_MAP_TYPE] == MAP_TRUE_COLOR && hdr[HDR_DATA_TYPE] == TYPE_UNCOMP_RGB &&
             (hdr[HDR_DEPTH] == DEPTH_24 || hdr[HDR_DEPTH] == DEPTH_32) && w != 0 && h != 0;
      cut_at = ($urandom_range(99) < 6) ? $urandom_range(17) : 18;
      for (i = 0; i < cut_at; i++) add_item(hdr[i], first_sof && i == 0, 1'b0, 1'b0, '0);
      if (cut_at < 18) begin
         add_item(8'($urandom_range(255)), first_sof && cut_at == 0, 1'b1, 1'b0, '0);
         return;
      end
      need = (hdr[HDR_DEPTH] == DEPTH_32) ? 4 : 3;
      if (!good) begin
         n_bytes   = $urandom_range(4);
         cut_short = 1'b0;
      end else if (w > 5 || h > 5) begin
         // Huge images are cut off early; they can still reach large destination indexes.
         n_bytes   = $urandom_range(40);
         cut_short = 1'b1;
      end else begin
         n_bytes   = int'(w) * int'(h) * need;
         cut_short = ($urandom_range(99) < 10);
         if (cut_short) n_bytes = $urandom_range(n_bytes - 1);
      end
      if (good) begin
         for (i = 0; i < hdr[HDR_ID_LENGTH]; i++)
            add_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
      end
      for (i = 0; i < n_bytes; i++)
         add_item(8'($urandom_range(255)), $urandom_range(199) == 0, 1'b0, 1'b0, '0);
      if (cut_short) add_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
      if ($urandom_range(99) < 30) begin
         repeat ($urandom_range(1, 3)) add_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
      end
      if ($urandom_range(99) < 10) add_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
   endtask

   task automatic send_item(input stim_row_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_data_byte     <= s.data;
      req_start_of_file <= s.sof;
      req_end_of_data   <= s.eod;
      row_fixed         <= s.fixed;
      row_want          <= s.want;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic string result_text(input result_type r);
      return $sformatf("kind=%0d err=%0d alpha=%0d w=%0d h=%0d pixel=%h index=%0d last=%0d",
                       r.result_kind, r.error_code, r.has_alpha, r.image_width,
                       r.image_height, r.pixel_value, r.dest_index, r.last_item);
   endfunction

   // Receiver: random stalls, plus one long hold-off when requested.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      logic       live;
      logic       got;
      result_type r;
      if (!reset && req_valid && !req_stall) begin
         decode_byte(req_data_byte, req_start_of_file, req_end_of_data, live, got, r);
         if (live) parsed_bytes++;
         if (row_fixed) decoded_queue.push_back(row_want);
         else if (got) decoded_queue.push_back(r);
      end
   end

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.result_kind  = rsp_result_kind;
         seen.error_code   = rsp_error_code;
         seen.has_alpha    = rsp_has_alpha;
         seen.image_width  = rsp_image_width;
         seen.image_height = rsp_image_height;
         seen.pixel_value  = rsp_pixel_value;
         seen.dest_index   = rsp_dest_index;
         seen.last_item    = rsp_last_item;
         if (decoded_queue.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("unexpected result: %s", result_text(seen));
            mismatch_count++;
         end else begin
            want = decoded_queue.pop_front();
            if (seen.result_kind !== want.result_kind || seen.error_code !== want.error_code ||
                seen.has_alpha !== want.has_alpha || seen.image_width !== want.image_width ||
                seen.image_height !== want.image_height ||
                seen.pixel_value !== want.pixel_value ||
                seen.dest_index !== want.dest_index || seen.last_item !== want.last_item) begin
               if (mismatch_count < MAX_REPORTS) begin
                  $display("mismatch expected: %s", result_text(want));
                  $display("mismatch actual:   %s", result_text(seen));
               end
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      result_type want;
      int         phase_idx;
      int         goal;
      clear_parser();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // An end right after reset and a start together with an end are both short headers.
      want             = '0;
      want.result_kind = KIND_ERROR;
      want.error_code  = ERR_SHORT_HEADER;
      want.last_item   = 1'b1;
      add_item(8'h5A, 1'b0, 1'b1, 1'b1, want);
      add_item(8'hA5, 1'b1, 1'b1, 1'b1, want);
      // A 1x1 32-bit image with a one-byte ID field and extreme filler bytes.
      add_item(8'h01, 1'b1, 1'b0, 1'b0, '0);           add_item(MAP_TRUE_COLOR, 1'b0, 1'b0, 1'b0, '0);
      add_item(TYPE_UNCOMP_RGB, 1'b0, 1'b0, 1'b0, '0); add_item(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_item(8'hFF, 1'b0, 1'b0, 1'b0, '0);           add_item(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_item(8'hFF, 1'b0, 1'b0, 1'b0, '0);           add_item(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_item(8'hFF, 1'b0, 1'b0, 1'b0, '0);           add_item(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_item(8'hFF, 1'b0, 1'b0, 1'b0, '0);           add_item(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_item(8'h01, 1'b0, 1'b0, 1'b0, '0);           add_item(8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_item(8'h01, 1'b0, 1'b0, 1'b0, '0);           add_item(8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_item(DEPTH_32, 1'b0, 1'b0, 1'b0, '0);
      want              = '0;
      want.result_kind  = KIND_HEADER;
      want.has_alpha    = 1'b1;
      want.image_width  = 16'd1;
      want.image_height = 16'd1;
      add_item(8'h00, 1'b0, 1'b0, 1'b1, want);
      add_item(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_item(8'h00, 1'b0, 1'b0, 1'b0, '0);           add_item(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_item(8'h00, 1'b0, 1'b0, 1'b0, '0);
      want.result_kind = KIND_PIXEL;
      want.pixel_value = 32'hFF00FF00;
      want.last_item   = 1'b1;
      add_item(8'hFF, 1'b0, 1'b0, 1'b1, want);
      // Trailing byte after the final pixel is dropped.
      add_item(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      while (stim_q.size() != 0) send_item(stim_q.pop_front());

      for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
         case (phase_idx)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  hold_request = 1'b1; end
            1: begin send_idle_pct = 73; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 73; end
            default: begin send_idle_pct = 17; rsp_stall_pct = 17; end
         endcase
         goal = parsed_bytes + ITEMS_PER_PHASE;
         while (parsed_bytes < goal) begin
            build_file();
            while (stim_q.size() != 0) send_item(stim_q.pop_front());
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (decoded_queue.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && decoded_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
